// ----- hdl/sacvb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacvb_pkg
// Shared types and codes for the set-associative cache with victim buffer.
// ----------------------------------------------------------------------------
package sacvb_pkg;

  // Access outcome codes
  typedef enum logic [1:0] {
    OUT_SET_HIT = 2'd0,
    OUT_BUF_HIT = 2'd1,
    OUT_MISS    = 2'd2
  } outcome_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_OUTPUT = 2'd3
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming access
    logic update;    // compare, replace and write back the set and buffer
    logic take_out;  // result transfer completed
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_full;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- hdl/sacvb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacvb_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// ----------------------------------------------------------------------------
module sacvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/sacvb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacvb_ctrl
// Sequencer: accept, read set, update, hand off result.
// ----------------------------------------------------------------------------
module sacvb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  out_ready,
  input  wire sacvb_pkg::ctrl_sts_t  sts,
  output sacvb_pkg::ctrl_cmd_t       cmd
);
  import sacvb_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.update   = 1'b0;
    cmd.take_out = sts.out_full & out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // result register must be free before the new result lands
        if (!sts.out_full || out_ready) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Update only runs after a read
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $past(state) == ST_READ || $past(state) == ST_UPDATE)
    else $error("update without set read");
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_READ)
    else $error("capture did not start a read");
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.update))
    else $error("capture and update together");

endmodule
`default_nettype wire

// ----- hdl/sacvb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacvb_dp
// Tag and set state RAMs per way, per-set touched flops, victim buffer and result register.
// ----------------------------------------------------------------------------
module sacvb_dp #(
  parameter int INDEX_BITS     = 8,
  parameter int OFFSET_BITS    = 6,
  parameter int WAYS           = 4,
  parameter int BUFFER_ENTRIES = 8,
  parameter int ADDRESS_BITS   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sacvb_pkg::ctrl_cmd_t cmd,
  output sacvb_pkg::ctrl_sts_t      sts,
  input  wire logic [31:0]          in_address,
  input  wire logic                 in_is_write,
  output logic [1:0]                out_outcome,
  output logic                      out_dropped,
  output logic                      out_ddirty,
  output logic [25:0]               out_dline
);
  import sacvb_pkg::*;

  localparam int SETS   = 1 << INDEX_BITS;
  localparam int LBITS  = ADDRESS_BITS - OFFSET_BITS;
  localparam int TBITS  = LBITS - INDEX_BITS;
  localparam int WA     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BA     = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
  localparam int MBITS  = 1 + 1 + WA;  // valid, dirty, age

  // Captured access
  logic [LBITS-1:0]      line;
  logic                  wr;
  logic [INDEX_BITS-1:0] idx;
  logic [TBITS-1:0]      tag;
  assign idx = line[INDEX_BITS-1:0];
  assign tag = line[LBITS-1:INDEX_BITS];

  logic [LBITS-1:0] cap_line;
  assign cap_line = LBITS'(ADDRESS_BITS'(in_address) >> OFFSET_BITS);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      line <= cap_line;
      wr   <= in_is_write;
    end
  end

  // Per-way storage: tags in RAM, valid/dirty/age in RAM with clean-on-reset
  // handled by a per-set "touched" bit (SETS flops, one per set)
  logic [TBITS-1:0] rd_tag   [WAYS];
  logic [MBITS-1:0] rd_meta  [WAYS];
  logic [TBITS-1:0] wr_tag   [WAYS];
  logic [MBITS-1:0] wr_meta  [WAYS];
  logic             wr_tag_en[WAYS];

  // Epoch-free reset: meta RAM read is masked by a touched bit per set.
  logic [SETS-1:0]  touched;
  logic             rd_touched;

  // Read the new set on capture, then keep reading the captured set
  logic [INDEX_BITS-1:0] rd_idx;
  assign rd_idx = cmd.capture ? cap_line[INDEX_BITS-1:0] : idx;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    sacvb_ram #(.WIDTH(TBITS), .DEPTH(SETS)) u_tag (
      .clk(clk), .we(cmd.update & wr_tag_en[w]), .waddr(idx), .wdata(wr_tag[w]),
      .raddr(rd_idx), .rdata(rd_tag[w]));
    sacvb_ram #(.WIDTH(MBITS), .DEPTH(SETS)) u_meta (
      .clk(clk), .we(cmd.update), .waddr(idx), .wdata(wr_meta[w]),
      .raddr(rd_idx), .rdata(rd_meta[w]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (cmd.update) begin
      touched[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_touched <= touched[cap_line[INDEX_BITS-1:0]];
    end
  end

  // Effective set state
  logic          va [WAYS];
  logic          di [WAYS];
  logic [WA-1:0] ag [WAYS];
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (rd_touched) begin
        va[w] = rd_meta[w][MBITS-1];
        di[w] = rd_meta[w][MBITS-2];
        ag[w] = rd_meta[w][WA-1:0];
      end else begin
        va[w] = 1'b0;
        di[w] = 1'b0;
        ag[w] = WA'(w);
      end
    end
  end

  // Victim buffer in flops
  logic [LBITS-1:0] b_line [BUFFER_ENTRIES];
  logic             b_va   [BUFFER_ENTRIES];
  logic             b_di   [BUFFER_ENTRIES];
  logic [BA-1:0]    b_ag   [BUFFER_ENTRIES];
  logic [LBITS-1:0] b_line_next [BUFFER_ENTRIES];
  logic             b_va_next   [BUFFER_ENTRIES];
  logic             b_di_next   [BUFFER_ENTRIES];
  logic [BA-1:0]    b_ag_next   [BUFFER_ENTRIES];

  // Lookups
  logic          set_hit, buf_hit, has_inv, buf_has_inv;
  logic [WA-1:0] hit_w, lru_w, inv_w;
  logic [BA-1:0] hit_e, lru_e, inv_e;
  always_comb begin
    set_hit = 1'b0; hit_w = '0; lru_w = '0; has_inv = 1'b0; inv_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (va[w] && rd_tag[w] == tag) begin
        set_hit = 1'b1; hit_w = WA'(w);
      end
      if (!va[w]) begin
        has_inv = 1'b1; inv_w = WA'(w);
      end
      if (ag[w] == WA'(WAYS - 1)) lru_w = WA'(w);
    end
    buf_hit = 1'b0; hit_e = '0; lru_e = '0; buf_has_inv = 1'b0; inv_e = '0;
    for (int e = BUFFER_ENTRIES - 1; e >= 0; e--) begin
      if (b_va[e] && b_line[e] == line) begin
        buf_hit = 1'b1; hit_e = BA'(e);
      end
      if (!b_va[e]) begin
        buf_has_inv = 1'b1; inv_e = BA'(e);
      end
      if (b_ag[e] == BA'(BUFFER_ENTRIES - 1)) lru_e = BA'(e);
    end
  end

  // Decisions
  logic          way_touch, buf_touch, buf_newest, buf_oldest, drop;
  logic [WA-1:0] slot;
  logic [BA-1:0] be;
  logic [1:0]    outcome;
  logic [LBITS-1:0] evict_line;
  logic          evict_dirty, slot_dirty;
  always_comb begin
    way_touch = 1'b1;
    buf_touch = 1'b0; buf_newest = 1'b0; buf_oldest = 1'b0; drop = 1'b0;
    slot = hit_w; be = hit_e; slot_dirty = wr;
    outcome = OUT_SET_HIT;
    evict_line  = {rd_tag[lru_w], idx};
    evict_dirty = di[lru_w];
    if (set_hit) begin
      slot = hit_w; slot_dirty = wr | di[hit_w];
    end else if (buf_hit) begin
      outcome = OUT_BUF_HIT; slot = lru_w; be = hit_e; buf_touch = 1'b1;
      slot_dirty = wr | b_di[hit_e];
      if (va[lru_w]) buf_newest = 1'b1;
      else buf_oldest = 1'b1;
    end else begin
      outcome = OUT_MISS; slot_dirty = wr;
      if (has_inv) begin
        slot = inv_w;
      end else begin
        slot = lru_w; buf_touch = 1'b1; buf_newest = 1'b1;
        if (buf_has_inv) begin
          be = inv_e;
        end else begin
          be = lru_e; drop = 1'b1;
        end
      end
    end
  end

  // Set write-back data
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_tag[w]    = tag;
      wr_tag_en[w] = way_touch && (WA'(w) == slot);
      if (WA'(w) == slot) begin
        wr_meta[w] = {1'b1, slot_dirty, {WA{1'b0}}};
      end else begin
        wr_meta[w] = {va[w], di[w], (ag[w] < ag[slot]) ? WA'(ag[w] + 1'b1) : ag[w]};
      end
    end
  end

  // Buffer next state
  always_comb begin
    for (int e = 0; e < BUFFER_ENTRIES; e++) begin
      b_line_next[e] = b_line[e];
      b_va_next[e]   = b_va[e];
      b_di_next[e]   = b_di[e];
      b_ag_next[e]   = b_ag[e];
      if (buf_touch) begin
        if (BA'(e) == be) begin
          if (buf_newest) begin
            b_line_next[e] = evict_line;
            b_va_next[e]   = 1'b1;
            b_di_next[e]   = evict_dirty;
            b_ag_next[e]   = '0;
          end else begin
            b_va_next[e]   = 1'b0;
            b_di_next[e]   = 1'b0;
            b_ag_next[e]   = BA'(BUFFER_ENTRIES - 1);
          end
        end else if (buf_newest && b_ag[e] < b_ag[be]) begin
          b_ag_next[e] = BA'(b_ag[e] + 1'b1);
        end else if (buf_oldest && b_ag[e] > b_ag[be]) begin
          b_ag_next[e] = BA'(b_ag[e] - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < BUFFER_ENTRIES; e++) begin
      if (rst) begin
        b_va[e] <= 1'b0;
        b_di[e] <= 1'b0;
        b_ag[e] <= BA'(e);
      end else if (cmd.update) begin
        b_va[e] <= b_va_next[e];
        b_di[e] <= b_di_next[e];
        b_ag[e] <= b_ag_next[e];
      end
      if (cmd.update) b_line[e] <= b_line_next[e];
    end
  end

  // Result register
  logic out_full;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.update) begin
      out_full <= 1'b1;
    end else if (cmd.take_out) begin
      out_full <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_outcome <= outcome;
      out_dropped <= drop;
      out_ddirty  <= drop & b_di[lru_e];
      out_dline   <= drop ? 26'(b_line[lru_e]) : '0;
    end
  end
  assign sts.out_full = out_full;

  // Sanity checks
  assert property (@(posedge clk) disable iff (rst)
    cmd.update && drop |-> !buf_has_inv)
    else $error("drop while buffer had a free entry");
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(set_hit && outcome != OUT_SET_HIT))
    else $error("set hit reported wrong");
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> out_full)
    else $error("result not held");

endmodule
`default_nettype wire

// ----- hdl/set_assoc_cache_with_victim_buffer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_with_victim_buffer_top
// Tag store of a set-associative LRU cache with a fully associative victim
// buffer; one result per access.
//
//   channel | dir | tdata                              | tuser
//   s_axis  | in  | address[31:0]                      | is_write
//   m_axis  | out | outcome, line_dropped, dropped_dirty, dropped_line | -
//
// An access goes through capture, set RAM read, then compare/update/write-back.
// The registered per-way RAM read makes up the set read step; one access at a time.
// Reset is synchronous; set state reads as empty until a set is first written.
// A stalled result holds the block in its update state until taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_with_victim_buffer_top #(
  parameter int INDEX_BITS     = 8,
  parameter int OFFSET_BITS    = 6,
  parameter int WAYS           = 4,
  parameter int BUFFER_ENTRIES = 8,
  parameter int ADDRESS_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // address[31:0]
  input  wire logic        s_axis_tuser,   // is_write
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // outcome[1:0], line_dropped[2],
                                           // dropped_dirty[3], dropped_line[29:4]
);
  import sacvb_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic [1:0]  outcome;
  logic        dropped, ddirty;
  logic [25:0] dline;

  sacvb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_ready(m_axis_tready), .sts(sts), .cmd(cmd));

  sacvb_dp #(
    .INDEX_BITS(INDEX_BITS), .OFFSET_BITS(OFFSET_BITS), .WAYS(WAYS),
    .BUFFER_ENTRIES(BUFFER_ENTRIES), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_address(s_axis_tdata), .in_is_write(s_axis_tuser),
    .out_outcome(outcome), .out_dropped(dropped), .out_ddirty(ddirty),
    .out_dline(dline));

  assign m_axis_tvalid = sts.out_full;
  assign m_axis_tdata  = {2'b00, dline, ddirty, dropped, outcome};

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the set-associative cache tag store with victim buffer.
// Accesses are driven with random sender gaps and receiver stalls; a
// scoreboard holds its own copy of the sets and victim buffer, predicts each
// access result and checks every output transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
  import sacvb_pkg::*;

  localparam int IDX_W   = 8;
  localparam int OFS_W   = 6;
  localparam int NWAY    = 4;
  localparam int NBUF    = 8;
  localparam int NSET    = 1 << IDX_W;
  localparam int TAG_W   = 32 - IDX_W - OFS_W;
  localparam int WDOG    = 20000;

  typedef struct packed {
    logic [25:0] dline;
    logic        ddirty;
    logic        dropped;
    outcome_t    outcome;
  } access_result_t;

  // Cache model and queue of predicted results
  class cache_scoreboard;
    logic [TAG_W-1:0] tag_q   [NSET][NWAY];
    bit               vld_q   [NSET][NWAY];
    bit               drt_q   [NSET][NWAY];
    int               age_q   [NSET][NWAY];
    logic [25:0]      bline_q [NBUF];
    bit               bvld_q  [NBUF];
    bit               bdrt_q  [NBUF];
    int               bage_q  [NBUF];
    access_result_t   pending [$];
    int               errors;

    function void clear();
      for (int s = 0; s < NSET; s++)
        for (int w = 0; w < NWAY; w++) begin
          tag_q[s][w] = '0; vld_q[s][w] = 0; drt_q[s][w] = 0; age_q[s][w] = w;
        end
      for (int e = 0; e < NBUF; e++) begin
        bline_q[e] = '0; bvld_q[e] = 0; bdrt_q[e] = 0; bage_q[e] = e;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void touch_way(int s, int w);
      int old;
      old = age_q[s][w];
      for (int i = 0; i < NWAY; i++) if (age_q[s][i] < old) age_q[s][i]++;
      age_q[s][w] = 0;
    endfunction

    function void touch_buf(int e);
      int old;
      old = bage_q[e];
      for (int i = 0; i < NBUF; i++) if (bage_q[i] < old) bage_q[i]++;
      bage_q[e] = 0;
    endfunction

    function void retire_buf(int e);
      int old;
      old = bage_q[e];
      for (int i = 0; i < NBUF; i++) if (bage_q[i] > old) bage_q[i]--;
      bage_q[e] = NBUF - 1;
    endfunction

    function int lru_way(int s);
      for (int i = 0; i < NWAY; i++) if (age_q[s][i] == NWAY - 1) return i;
      return 0;
    endfunction

    function int lru_buf();
      for (int i = 0; i < NBUF; i++) if (bage_q[i] == NBUF - 1) return i;
      return 0;
    endfunction

    // Predict the result of one accepted access and update the model
    function void note_access(logic [31:0] addr, bit wr);
      access_result_t r;
      logic [25:0] ln;
      logic [TAG_W-1:0] tg;
      int s, slot, be;
      bit done, bd;
      r = '0;
      r.outcome = OUT_MISS;
      ln = addr[31:OFS_W];
      s = addr[OFS_W +: IDX_W];
      tg = addr[31 -: TAG_W];
      done = 0;
      for (int w = 0; w < NWAY && !done; w++)
        if (vld_q[s][w] && tag_q[s][w] == tg) begin
          if (wr) drt_q[s][w] = 1;
          touch_way(s, w);
          r.outcome = OUT_SET_HIT;
          done = 1;
        end
      for (int e = 0; e < NBUF && !done; e++)
        if (bvld_q[e] && bline_q[e] == ln) begin
          bd = bdrt_q[e];
          slot = lru_way(s);
          if (vld_q[s][slot]) begin
            bline_q[e] = {tag_q[s][slot], s[IDX_W-1:0]};
            bdrt_q[e] = drt_q[s][slot];
            touch_buf(e);
          end else begin
            bvld_q[e] = 0; bdrt_q[e] = 0;
            retire_buf(e);
          end
          tag_q[s][slot] = tg; vld_q[s][slot] = 1; drt_q[s][slot] = wr | bd;
          touch_way(s, slot);
          r.outcome = OUT_BUF_HIT;
          done = 1;
        end
      if (!done) begin
        slot = NWAY;
        for (int w = NWAY - 1; w >= 0; w--) if (!vld_q[s][w]) slot = w;
        if (slot == NWAY) begin
          slot = lru_way(s);
          be = NBUF;
          for (int e = NBUF - 1; e >= 0; e--) if (!bvld_q[e]) be = e;
          if (be == NBUF) begin
            be = lru_buf();
            r.dropped = 1; r.ddirty = bdrt_q[be]; r.dline = bline_q[be];
          end
          bline_q[be] = {tag_q[s][slot], s[IDX_W-1:0]};
          bvld_q[be] = 1; bdrt_q[be] = drt_q[s][slot];
          touch_buf(be);
        end
        tag_q[s][slot] = tg; vld_q[s][slot] = 1; drt_q[s][slot] = wr;
        touch_way(s, slot);
      end
      pending.push_back(r);
    endfunction

    task check_result(logic [31:0] data);
      access_result_t got, exp;
      got = data[29:0];
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected result %h", data));
        return;
      end
      exp = pending.pop_front();
      if (data[31:30] !== 2'b00) report_error($sformatf("pad bits set %h", data));
      if (got.outcome !== exp.outcome)
        report_error($sformatf("outcome %0d exp %0d", got.outcome, exp.outcome));
      if (got.dropped !== exp.dropped)
        report_error($sformatf("line_dropped %0b exp %0b", got.dropped, exp.dropped));
      if (got.ddirty !== exp.ddirty)
        report_error($sformatf("dropped_dirty %0b exp %0b", got.ddirty, exp.ddirty));
      if (got.dline !== exp.dline)
        report_error($sformatf("dropped_line %h exp %h", got.dline, exp.dline));
    endtask

    task report_error(string msg);
      errors++;
      if (errors <= 50) $display("ERROR @%0t: %s", $time, msg);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;

  cache_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  quiet_cycles = 0;
  logic [31:0] hot_addr [16];

  always #5 clk = ~clk;

  set_assoc_cache_with_victim_buffer_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Scoreboard hooks and watchdog on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_access(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a counted long hold-off on request
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off > 0) begin
      m_axis_tready <= 0;
      hold_off <= hold_off - 1;
    end else
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One access transfer; idles are inserted before offering
  task automatic send_access(logic [31:0] addr, bit wr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= wr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Mostly well-formed traffic: a small working set over few sets so that
  // sets fill, lines go to the buffer and the buffer overflows
  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(99);
    if (k < 70) return hot_addr[$urandom_range(15)] | $urandom_range(63);
    if (k < 85) return {$urandom_range(3) == 0 ? $urandom() : {12'h0, 20'($urandom())}} &
                       32'hFFFF_FFC0 | {24'h0, 2'($urandom_range(1)), 6'($urandom())} ;
    return $urandom();
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0)
        for (int h = 0; h < 16; h++)
          hot_addr[h] = {14'($urandom()), 6'h0, 2'($urandom_range(1)), 10'($urandom())};
      send_access(pick_addr(), $urandom_range(1));
    end
  endtask

  initial begin
    sb.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: fill set 0 with five tags, revisit, overflow the buffer
    for (int t = 0; t < 5; t++) send_access({18'(t), 8'h00, 6'h3F}, t[0]);
    send_access({18'd4, 8'h00, 6'h00}, 1);     // set hit, write
    send_access({18'd0, 8'h00, 6'h00}, 0);     // buffer hit with swap
    send_access({18'd0, 8'h01, 6'h00}, 1);     // fill invalid way in set 1
    for (int t = 0; t < 12; t++) send_access({18'h3FFFF - 18'(t), 8'hFF, 6'h00}, 1);
    send_access({18'h3FFFF, 8'hFF, 6'h3F}, 0); // drop line back via buffer/miss
    send_access(32'hFFFF_FFFF, 1);
    send_access(32'h0000_0000, 0);
    wait_drained();
    // Revisit tag 1 in set 0, a line that was swapped out to the victim buffer earlier
    send_access({18'd1, 8'h00, 6'h00}, 0);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 300;
    random_phase(30, 0, 0);
    wait_drained();

    random_phase(120, 0, 0);
    random_phase(120, 75, 0);
    random_phase(120, 0, 75);
    random_phase(120, 10, 10);
    wait_drained();

    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/sacvb_pkg.sv
hdl/sacvb_ram.sv
hdl/sacvb_ctrl.sv
hdl/sacvb_dp.sv
hdl/set_assoc_cache_with_victim_buffer_top.sv
tb/tb.sv
